// ===== rtl/core/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int ANGLE_WIDTH = 16;
	localparam int OUT_WIDTH   = 16;
	localparam int STEPS       = 28;
	localparam int FRAC        = 30;
	localparam int CW          = 33;           // CORDIC x/y width, Q30 plus sign/headroom
	localparam int ZW          = 34;           // residual angle width
	localparam int QDEPTH      = 4;
	localparam int QAW         = 2;
	localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

	typedef struct packed {
		logic signed [ANGLE_WIDTH-1:0] angle_x;
		logic signed [ANGLE_WIDTH-1:0] angle_y;
		logic signed [ANGLE_WIDTH-1:0] angle_z;
	} e2q_in_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] quat_x;
		logic signed [OUT_WIDTH-1:0] quat_y;
		logic signed [OUT_WIDTH-1:0] quat_z;
		logic signed [OUT_WIDTH-1:0] quat_w;
	} e2q_out_t;

	typedef struct packed {
		logic signed [CW-1:0] sx, cx, sy, cy, sz, cz;
	} e2q_sc_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/e2q_front.sv =====
// ----------------------------------------------------------------------------
// e2q_front
// Front end: 28-stage unrolled CORDIC, three angles in parallel lanes.
// Pipeline advances when the queue has a free slot reserved.
// ----------------------------------------------------------------------------
module e2q_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             stall,
	input  e2q_pkg::e2q_in_t data,
	input  logic             q_credit,   // queue can take one more item this cycle
	output logic             sc_valid,
	output e2q_pkg::e2q_sc_t sc_data
);
	import e2q_pkg::*;

	logic                 vld_q [STEPS+1];
	logic signed [CW-1:0] x_q [3][STEPS+1];
	logic signed [CW-1:0] y_q [3][STEPS+1];
	logic signed [ZW-1:0] z_q [3][STEPS+1];
	logic                 adv;
	logic [ANGLE_WIDTH-1:0] ang [3];

	assign adv   = q_credit;
	assign stall = !q_credit;
	assign ang[0] = data.angle_x;
	assign ang[1] = data.angle_y;
	assign ang[2] = data.angle_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= STEPS; s++) vld_q[s] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= valid;
			for (int s = 1; s <= STEPS; s++) vld_q[s] <= vld_q[s-1];
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (adv) begin
				x_q[l][0] <= GAIN_Q30;
				y_q[l][0] <= '0;
				z_q[l][0] <= {{(ZW-32){ang[l][ANGLE_WIDTH-1]}}, ang[l],
					{(32-ANGLE_WIDTH){1'b0}}};
			end
		end
		for (genvar s = 0; s < STEPS; s++) begin : g_step
			logic signed [ZW-1:0] da;
			assign da = {{(ZW-33){1'b0}}, atan_lut(5'(s)), 1'b0};
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!z_q[l][s][ZW-1]) begin
						x_q[l][s+1] <= x_q[l][s] - (y_q[l][s] >>> s);
						y_q[l][s+1] <= y_q[l][s] + (x_q[l][s] >>> s);
						z_q[l][s+1] <= z_q[l][s] - da;
					end else begin
						x_q[l][s+1] <= x_q[l][s] + (y_q[l][s] >>> s);
						y_q[l][s+1] <= y_q[l][s] - (x_q[l][s] >>> s);
						z_q[l][s+1] <= z_q[l][s] + da;
					end
				end
			end
		end
	end

	assign sc_valid   = vld_q[STEPS] && adv;
	assign sc_data.sx = y_q[0][STEPS];
	assign sc_data.cx = x_q[0][STEPS];
	assign sc_data.sy = y_q[1][STEPS];
	assign sc_data.cy = x_q[1][STEPS];
	assign sc_data.sz = y_q[2][STEPS];
	assign sc_data.cz = x_q[2][STEPS];

endmodule

// ===== rtl/core/e2q_queue.sv =====
// ----------------------------------------------------------------------------
// e2q_queue
// Queue between CORDIC front and product back end. Flop storage, gives
// the front a credit while fewer than QDEPTH-1 items are stored or one is read.
// ----------------------------------------------------------------------------
module e2q_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  e2q_pkg::e2q_sc_t wdata,
	output logic             rd_valid,
	input  logic             rd,
	output e2q_pkg::e2q_sc_t rdata,
	output logic             credit
);
	import e2q_pkg::*;

	e2q_sc_t        mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;

	// front stalls as a whole, so only one item can land per advance
	assign credit   = (cnt_q < (QAW+1)'(QDEPTH-1)) || rd;
	assign rd_valid = cnt_q != '0;
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(wr) - (QAW+1)'(rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && !rd && cnt_q == (QAW+1)'(QDEPTH)))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && cnt_q == '0))
		else $error("queue underflow");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(QDEPTH))
		else $error("queue count out of range");

endmodule

// ===== rtl/core/e2q_back.sv =====
// ----------------------------------------------------------------------------
// e2q_back
// Back end: pair products (rounded Q30), triple products, sum, round,
// saturate. Elastic pipeline with output register.
// ----------------------------------------------------------------------------
module e2q_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  e2q_pkg::e2q_sc_t  sc,
	output logic              valid,
	input  logic              stall,
	output e2q_pkg::e2q_out_t data
);
	import e2q_pkg::*;

	localparam int PW = 2*CW;        // pair product
	localparam int TW = 2*CW + 2;    // Q60 term
	localparam int SH = 2*FRAC - (OUT_WIDTH-1);

	logic v_s1, v_s2, v_s3, v_q;
	logic adv;
	logic signed [CW-1:0] p_s1 [8];
	logic signed [CW-1:0] c_s1 [8];
	logic signed [TW-1:0] t_s2 [8];
	logic signed [TW:0]   s_s3 [4];
	e2q_out_t             data_q;

	assign adv      = !v_q || !stall;
	assign in_ready = adv;
	assign valid    = v_q;
	assign data     = data_q;

	function automatic logic signed [CW-1:0] rq(input logic signed [CW-1:0] a,
	                                            input logic signed [CW-1:0] b);
		logic signed [PW-1:0] p;
		logic signed [PW-1:0] r;
		p = a * b;
		r = (p + (PW'(1) <<< (FRAC-1))) >>> FRAC;
		return r[CW-1:0];
	endfunction

	function automatic logic signed [OUT_WIDTH-1:0] sat(input logic signed [TW:0] v);
		logic signed [TW:0] r;
		r = (v + ((TW+1)'(1) <<< (SH-1))) >>> SH;
		if (r > (TW+1)'((1 <<< (OUT_WIDTH-1)) - 1)) return {1'b0, {(OUT_WIDTH-1){1'b1}}};
		if (r < -((TW+1)'(1) <<< (OUT_WIDTH-1)))     return {1'b1, {(OUT_WIDTH-1){1'b0}}};
		return r[OUT_WIDTH-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// terms: x = cz sx cy - sz cx sy, y = cz cx sy + sz sx cy
			//        z = sz cx cy - cz sx sy, w = cz cx cy + sz sx sy
			p_s1[0] <= rq(sc.cz, sc.sx); c_s1[0] <= sc.cy;
			p_s1[1] <= rq(sc.sz, sc.cx); c_s1[1] <= sc.sy;
			p_s1[2] <= rq(sc.cz, sc.cx); c_s1[2] <= sc.sy;
			p_s1[3] <= rq(sc.sz, sc.sx); c_s1[3] <= sc.cy;
			p_s1[4] <= rq(sc.sz, sc.cx); c_s1[4] <= sc.cy;
			p_s1[5] <= rq(sc.cz, sc.sx); c_s1[5] <= sc.sy;
			p_s1[6] <= rq(sc.cz, sc.cx); c_s1[6] <= sc.cy;
			p_s1[7] <= rq(sc.sz, sc.sx); c_s1[7] <= sc.sy;
			for (int k = 0; k < 8; k++)
				t_s2[k] <= TW'(p_s1[k]) * TW'(c_s1[k]);
			s_s3[0] <= (TW+1)'(t_s2[0]) - (TW+1)'(t_s2[1]);
			s_s3[1] <= (TW+1)'(t_s2[2]) + (TW+1)'(t_s2[3]);
			s_s3[2] <= (TW+1)'(t_s2[4]) - (TW+1)'(t_s2[5]);
			s_s3[3] <= (TW+1)'(t_s2[6]) + (TW+1)'(t_s2[7]);
			data_q.quat_x <= sat(s_s3[0]);
			data_q.quat_y <= sat(s_s3[1]);
			data_q.quat_z <= sat(s_s3[2]);
			data_q.quat_w <= sat(s_s3[3]);
		end
	end

endmodule

// ===== rtl/core/euler_to_quaternion_top.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion_top
// Z-Y-X Euler angles (binary angle, 32768 = pi) to a Q1.15 unit quaternion.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out, one item per cycle sustained while the
// output is not stalled. An item passes the CORDIC pipeline, then the queue,
// then the products and rounding. The CORDIC front is one unrolled 28-step
// pipeline per angle; the back end multiplies and saturates. A 4-entry queue
// parts the two, so a stall on the output stops the back end first and the
// front only when the queue nears full. No state survives an item; reset only
// clears valid bits and queue pointers.
module euler_to_quaternion_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  e2q_pkg::e2q_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output e2q_pkg::e2q_out_t out_data
);
	import e2q_pkg::*;

	logic    sc_valid, credit, q_valid, q_rd, b_ready;
	e2q_sc_t sc_data, q_data;

	e2q_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .data(in_data),
		.q_credit(credit), .sc_valid, .sc_data
	);

	assign q_rd = q_valid && b_ready;

	e2q_queue u_queue (
		.clk, .arst_n, .wr(sc_valid), .wdata(sc_data), .rd_valid(q_valid),
		.rd(q_rd), .rdata(q_data), .credit
	);

	e2q_back u_back (
		.clk, .arst_n, .in_valid(q_rd), .in_ready(b_ready), .sc(q_data),
		.valid(out_valid), .stall(out_stall), .data(out_data)
	);

endmodule
